// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define CISA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen.
`define CISA_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/cisa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cisa_pkg;

  localparam int SLOT_MAX_W = 16;
  localparam logic [31:0] SKIP_ID = 32'hbabeface;

  typedef enum logic [1:0] {
    FUNC_PUT     = 2'd0,
    FUNC_GET     = 2'd1,
    FUNC_RELEASE = 2'd2
  } func_t;

  typedef struct packed {
    func_t       func;
    logic [30:0] handle_in;
    logic [31:0] id_in;
  } cmd_t;

  typedef struct packed {
    logic [31:0] id_out;
    logic [30:0] handle_out;
    logic        released;
    logic        overwrote;
  } result_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [SLOT_MAX_W-1:0] slot;
  } job_t;

  typedef struct packed {
    logic                  valid;
    logic [SLOT_MAX_W-1:0] slot;
  } slot_load_t;

  typedef struct packed {
    logic [31:0] id;
    logic [30:0] handle;
  } slot_entry_t;

endpackage

`default_nettype wire

// ===== rtl/cisa_mod.sv =====
`timescale 1ns / 1ps
`default_nettype none

// id mod SLOTS: a registered mask for a power of two, else a registered reciprocal multiply.
// A new start drops any reduction still in progress.
module cisa_mod #(
  parameter int SLOTS = 1024,
  parameter int IDX_W = 10
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [31:0]      value,
  output logic                  done,
  output logic [IDX_W-1:0]      rem
);

  localparam bit IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);

  if (IS_POW2) begin : g_mask
    always_ff @(posedge clk) begin
      if (rst) begin
        done <= 1'b0;
      end else begin
        done <= start;
      end
      if (start) begin
        rem <= value[IDX_W-1:0] & IDX_W'(SLOTS - 1);
      end
    end
  end else begin : g_recip
    // q = (t + ((x - t) >> 1)) >> (L - 1), t = high word of x * MAGIC
    localparam int          L      = $clog2(SLOTS);
    localparam logic [63:0] M_WIDE = ((64'd1 << 32) * ((64'd1 << L) - 64'(SLOTS)))
                                     / 64'(SLOTS) + 64'd1;
    localparam logic [31:0] MAGIC  = M_WIDE[31:0];

    logic [31:0] x;
    logic [63:0] prod;
    logic [31:0] t;
    logic [31:0] q;
    logic [47:0] qd;
    logic [31:0] diff;
    logic [1:0]  phase;

    assign t    = prod[63:32];
    assign qd   = 48'(q) * 48'(SLOTS);
    assign diff = x - qd[31:0];

    always_ff @(posedge clk) begin
      if (rst) begin
        phase <= 2'd0;
        done  <= 1'b0;
      end else begin
        done <= 1'b0;
        if (start) begin
          phase <= 2'd1;
        end else if (phase == 2'd1) begin
          phase <= 2'd2;
        end else if (phase == 2'd2) begin
          phase <= 2'd0;
          done  <= 1'b1;
        end
      end
      if (start) begin
        x    <= value;
        prod <= 64'(value) * 64'(MAGIC);
      end
      if (phase == 2'd1) begin
        q <= (t + ((x - t) >> 1)) >> (L - 1);
      end
      if (phase == 2'd2) begin
        rem <= diff[IDX_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cisa_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-entry job queue between front and back.
module cisa_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire cisa_pkg::job_t push_job,
  input  wire logic          pop,
  output cisa_pkg::job_t     pop_job,
  output logic               full,
  output logic               empty
);
  import cisa_pkg::*;

`include "assert_macros.svh"

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  `CISA_NEVER(a_push_full, push && full, "queue overflow")
  `CISA_NEVER(a_pop_empty, pop && empty, "queue underflow")

endmodule

`default_nettype wire

// ===== rtl/cisa_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Command intake: reduces ids to slot numbers and queues jobs.
module cisa_front #(
  parameter int SLOTS = 1024,
  parameter int IDX_W = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire cisa_pkg::cmd_t       cmd,
  input  wire logic                 cfg_we,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 clearing,
  input  wire logic                 full,
  output logic                      push,
  output cisa_pkg::job_t            push_job,
  output cisa_pkg::slot_load_t      slot_load
);
  import cisa_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CALC_CMD,
    F_CALC_CFG,
    F_PUSH
  } fstate_t;

  fstate_t               state;
  cmd_t                  held;
  logic [SLOT_MAX_W-1:0] held_slot;
  logic                  accept;
  logic                  needs_mod;
  logic                  mod_start;
  logic [31:0]           mod_value;
  logic                  mod_done;
  logic [IDX_W-1:0]      mod_rem;

  assign busy      = (state != F_IDLE) || full || clearing;
  assign accept    = start && !busy;
  assign needs_mod = (cmd.func == FUNC_GET) || (cmd.func == FUNC_RELEASE);
  // a new start_id write restarts the reduction
  assign mod_start = (cfg_we && (state inside {F_IDLE, F_CALC_CFG})) ||
                     ((state == F_IDLE) && accept && needs_mod);
  assign mod_value = cfg_we ? cfg_data : cmd.id_in;

  cisa_mod #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (mod_start),
    .value (mod_value),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_comb begin
    push     = 1'b0;
    push_job = '{cmd: held, slot: held_slot};
    case (state)
      F_IDLE: begin
        if (accept && !needs_mod) begin
          push     = 1'b1;
          push_job = '{cmd: cmd, slot: '0};
        end
      end
      F_CALC_CMD: begin
        if (mod_done && !full) begin
          push     = 1'b1;
          push_job = '{cmd: held, slot: SLOT_MAX_W'(mod_rem)};
        end
      end
      F_PUSH: begin
        push = !full;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= F_IDLE;
      slot_load.valid <= 1'b0;
    end else begin
      slot_load.valid <= 1'b0;
      case (state)
        F_IDLE: begin
          if (cfg_we) begin
            state <= F_CALC_CFG;
          end else if (accept && needs_mod) begin
            state <= F_CALC_CMD;
          end
        end
        F_CALC_CMD: begin
          if (mod_done) begin
            state <= full ? F_PUSH : F_IDLE;
          end
        end
        F_CALC_CFG: begin
          if (!cfg_we && mod_done) begin
            slot_load.valid <= 1'b1;
            state           <= F_IDLE;
          end
        end
        F_PUSH: begin
          if (!full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
    if (accept) begin
      held <= cmd;
    end
    if (mod_done) begin
      held_slot      <= SLOT_MAX_W'(mod_rem);
      slot_load.slot <= SLOT_MAX_W'(mod_rem);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cisa_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Table engine: id counter, slot memory, probing and release.
module cisa_back #(
  parameter int SLOTS = 1024,
  parameter int IDX_W = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [31:0]          cfg_data,
  input  wire cisa_pkg::slot_load_t slot_load,
  input  wire logic                 empty,
  input  wire cisa_pkg::job_t       job,
  output logic                      pop,
  output logic                      clearing,
  output logic                      done,
  output cisa_pkg::result_t         result
);
  import cisa_pkg::*;

`include "assert_macros.svh"

  localparam int TRY_W = $clog2(SLOTS + 1);
  localparam logic [IDX_W-1:0] START_SLOT_RST = IDX_W'(1 % SLOTS);
  localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOTS - 1);

  typedef enum logic [1:0] {
    B_CLEAR,
    B_IDLE,
    B_PROBE,
    B_ACCESS
  } bstate_t;

  bstate_t          state;
  logic [31:0]      start_id;
  logic [IDX_W-1:0] start_slot;
  logic [31:0]      cnt;
  logic [IDX_W-1:0] cnt_slot;
  logic [TRY_W-1:0] tries;
  cmd_t             cur;
  logic [IDX_W-1:0] cur_slot;
  logic [IDX_W-1:0] clear_idx;

  slot_entry_t      mem [SLOTS];
  slot_entry_t      rd_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  slot_entry_t      wr_data;

  logic [31:0]      inc;
  logic [31:0]      adv_cnt;
  logic [IDX_W-1:0] adv_slot;
  logic             slot_busy;
  logic             probe_more;
  logic             id_match;

  // next id and its slot
  always_comb begin
    inc = cnt + 32'd1;
    if (inc == SKIP_ID) begin
      adv_cnt  = start_id;
      adv_slot = start_slot;
    end else if (inc == 32'd0) begin
      adv_cnt  = '0;
      adv_slot = '0;
    end else if (cnt_slot == LAST_SLOT) begin
      adv_cnt  = inc;
      adv_slot = '0;
    end else begin
      adv_cnt  = inc;
      adv_slot = cnt_slot + IDX_W'(1);
    end
  end

  assign clearing   = (state == B_CLEAR);
  assign pop        = (state == B_IDLE) && !empty;
  assign slot_busy  = (rd_data.id != 32'd0);
  assign probe_more = slot_busy && (tries != TRY_W'(SLOTS));
  assign id_match   = (rd_data.id == cur.id_in);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = adv_slot;
    wr_en   = 1'b0;
    wr_addr = cur_slot;
    wr_data = '{id: cnt, handle: cur.handle_in};
    case (state)
      B_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clear_idx;
        wr_data = '0;
      end
      B_IDLE: begin
        if (pop && job.cmd.func == FUNC_PUT) begin
          rd_en = 1'b1;
        end else if (pop) begin
          rd_en   = 1'b1;
          rd_addr = job.slot[IDX_W-1:0];
        end
      end
      B_PROBE: begin
        if (probe_more) begin
          rd_en = 1'b1;
        end else begin
          wr_en = 1'b1;
        end
      end
      B_ACCESS: begin
        wr_en   = (cur.func == FUNC_RELEASE) && id_match;
        wr_data = '{id: 32'd0, handle: rd_data.handle};
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_CLEAR;
      clear_idx  <= '0;
      done       <= 1'b0;
      start_id   <= 32'd1;
      cnt        <= 32'd1;
      start_slot <= START_SLOT_RST;
      cnt_slot   <= START_SLOT_RST;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        start_id <= cfg_data;
        cnt      <= cfg_data;
      end
      if (slot_load.valid) begin
        start_slot <= slot_load.slot[IDX_W-1:0];
        cnt_slot   <= slot_load.slot[IDX_W-1:0];
      end
      case (state)
        B_CLEAR: begin
          clear_idx <= clear_idx + IDX_W'(1);
          if (clear_idx == LAST_SLOT) begin
            state <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (pop) begin
            case (job.cmd.func)
              FUNC_PUT: begin
                cnt      <= adv_cnt;
                cnt_slot <= adv_slot;
                state    <= B_PROBE;
              end
              FUNC_GET, FUNC_RELEASE: begin
                state <= B_ACCESS;
              end
              default: begin
                done   <= 1'b1;
                result <= '0;
              end
            endcase
          end
        end
        B_PROBE: begin
          if (probe_more) begin
            cnt      <= adv_cnt;
            cnt_slot <= adv_slot;
          end else begin
            done   <= 1'b1;
            result <= '{id_out: cnt, handle_out: cur.handle_in,
                        released: 1'b0, overwrote: slot_busy};
            state  <= B_IDLE;
          end
        end
        B_ACCESS: begin
          done   <= 1'b1;
          result <= '{id_out: rd_data.id, handle_out: rd_data.handle,
                      released: (cur.func == FUNC_RELEASE) && id_match,
                      overwrote: 1'b0};
          state  <= B_IDLE;
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
    if (pop) begin
      cur      <= job.cmd;
      cur_slot <= (job.cmd.func == FUNC_PUT) ? adv_slot : job.slot[IDX_W-1:0];
      tries    <= TRY_W'(1);
    end else if (state == B_PROBE && probe_more) begin
      cur_slot <= adv_slot;
      tries    <= tries + TRY_W'(1);
    end
  end

  `CISA_ASSERT(a_ovw_after_all, done && result.overwrote |-> $past(tries) == TRY_W'(SLOTS), "overwrite before all probes")
  `CISA_NEVER(a_flags_excl, done && result.released && result.overwrote, "release and overwrite together")

endmodule

`default_nettype wire

// ===== rtl/connection_id_slot_allocator.sv =====
// Flow: get/release reduce the id to its slot in the front (a mask if SLOTS is a power of
//   two, else a reciprocal multiply); a put is queued at once and probes in the back end.
// Throughput: the back end works one job at a time, one probe a cycle on the single slot
//   memory port for a put; the front takes a beat only while not busy (reducing, queue full).
// Reset: a clearing pass zeroes the id table with busy high; a start_id write holds busy
//   until its slot is reduced. Results show one cycle; no receiver stall.
`timescale 1ns / 1ps
`default_nettype none

module connection_id_slot_allocator #(
  parameter int SLOTS = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire cisa_pkg::cmd_t    cmd,
  output logic                   done,
  output cisa_pkg::result_t      result,
  input  wire logic              cfg_we,
  input  wire logic [31:0]       cfg_data
);
  import cisa_pkg::*;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic       push;
  job_t       push_job;
  logic       pop;
  job_t       pop_job;
  logic       full;
  logic       empty;
  logic       clearing;
  slot_load_t slot_load;

  cisa_front #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .full      (full),
    .push      (push),
    .push_job  (push_job),
    .slot_load (slot_load)
  );

  cisa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .full     (full),
    .empty    (empty)
  );

  cisa_back #(
    .SLOTS (SLOTS),
    .IDX_W (IDX_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .slot_load (slot_load),
    .empty     (empty),
    .job       (pop_job),
    .pop       (pop),
    .clearing  (clearing),
    .done      (done),
    .result    (result)
  );

endmodule

`default_nettype wire

// ===== tb/connection_id_slot_allocator_checker.sv =====
`timescale 1ns / 1ps

module connection_id_slot_allocator_checker #(
  parameter int SLOTS = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  cisa_pkg::cmd_t      cmd,
  input  logic                done,
  input  cisa_pkg::result_t   result,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_data,
  output int                  errors
);
  import cisa_pkg::*;

  logic [31:0] base_id;
  logic [31:0] conn_ctr;
  logic [31:0] table_id [SLOTS];
  logic [30:0] table_handle [SLOTS];
  result_t     pending_results [$];
  int          mismatches = 0;

  assign errors = mismatches;

  function automatic int slot_of(logic [31:0] id);
    return int'(id % 32'(SLOTS));
  endfunction

  function automatic logic [31:0] next_conn_id();
    conn_ctr = conn_ctr + 32'd1;
    if (conn_ctr == SKIP_ID) begin
      conn_ctr = base_id;
    end
    return conn_ctr;
  endfunction

  function automatic result_t apply_cmd(cmd_t c);
    result_t     r;
    int          tries;
    int          s;
    logic [31:0] sid;
    r = '0;
    s = slot_of(c.id_in);
    case (c.func)
      FUNC_PUT: begin
        tries = SLOTS;
        sid = next_conn_id();
        s = slot_of(sid);
        while (table_id[s] != '0 && tries > 1) begin
          tries--;
          sid = next_conn_id();
          s = slot_of(sid);
        end
        r.overwrote = (table_id[s] != '0);
        table_id[s] = sid;
        table_handle[s] = c.handle_in;
        r.id_out = sid;
        r.handle_out = c.handle_in;
      end
      FUNC_GET: begin
        r.id_out = table_id[s];
        r.handle_out = table_handle[s];
      end
      FUNC_RELEASE: begin
        r.id_out = table_id[s];
        r.handle_out = table_handle[s];
        if (table_id[s] == c.id_in) begin
          table_id[s] = '0;
          r.released = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic note_mismatch(string what, result_t w, result_t g);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t %s: exp id=%h handle=%h rel=%b ovw=%b, got id=%h handle=%h rel=%b ovw=%b",
               $time, what, w.id_out, w.handle_out, w.released, w.overwrote,
               g.id_out, g.handle_out, g.released, g.overwrote);
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      base_id = 32'd1;
      conn_ctr = 32'd1;
      for (int i = 0; i < SLOTS; i++) begin
        table_id[i] = '0;
        table_handle[i] = '0;
      end
      pending_results.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result", '0, result);
        end else begin
          want = pending_results.pop_front();
          if (want.id_out !== result.id_out || want.handle_out !== result.handle_out ||
              want.released !== result.released || want.overwrote !== result.overwrote) begin
            note_mismatch("result mismatch", want, result);
          end
        end
      end
      if (cfg_we) begin
        base_id = cfg_data;
        conn_ctr = cfg_data;
      end
      if (start && !busy) begin
        pending_results.push_back(apply_cmd(cmd));
      end
    end
  end

endmodule

// ===== tb/connection_id_slot_allocator_tb.sv =====
`timescale 1ns / 1ps

module connection_id_slot_allocator_tb;
  import cisa_pkg::*;

  localparam int          SLOTS        = 1024;
  localparam int          CYCLE_LIMIT  = 400000;
  localparam func_t       FUNC_NONE    = func_t'(2'd3);
  localparam logic [31:0] START_ID_MAX = SKIP_ID - 32'd1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  cmd_t        cmd = '0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        busy;
  logic        done;
  result_t     result;
  int          errors;
  int          cycles = 0;

  bit          slot_used [SLOTS];
  int          used_slots [$];
  logic [31:0] live_ids [$];
  func_t       inflight [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  connection_id_slot_allocator #(.SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  connection_id_slot_allocator_checker #(.SLOTS(SLOTS)) chk (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .cmd      (cmd),
    .done     (done),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .errors   (errors)
  );

  // learn which slots hold a handle from the ids that puts hand back
  always @(posedge clk) begin : track
    func_t f;
    int    s;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[connection_id_slot_allocator] ERROR");
      $finish;
    end
    if (!rst && done && inflight.size() != 0) begin
      f = inflight.pop_front();
      if (f == FUNC_PUT) begin
        s = int'(result.id_out % 32'(SLOTS));
        if (!slot_used[s]) begin
          slot_used[s] = 1'b1;
          used_slots.push_back(s);
        end
        live_ids.push_back(result.id_out);
      end
    end
  end

  function automatic cmd_t make_cmd(func_t f, logic [30:0] h, logic [31:0] id);
    cmd_t c;
    c.func = f;
    c.handle_in = h;
    c.id_in = id;
    return c;
  endfunction

  function automatic logic [31:0] used_slot_id();
    logic [31:0] id;
    int          s;
    s = used_slots[$urandom_range(used_slots.size() - 1)];
    id = $urandom();
    return id - (id % 32'(SLOTS)) + 32'(s);
  endfunction

  // one beat per call; start stays high on return
  task automatic send(cmd_t c, int idle_pct);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
    inflight.push_back(c.func);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (inflight.size() != 0) @(posedge clk);
  endtask

  task automatic set_start_id(logic [31:0] v);
    drain();
    do @(posedge clk); while (busy);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(int n, int idle_pct, bit hold_mid);
    cmd_t c;
    int   r;
    int   k;
    for (int i = 0; i < n; i++) begin
      if (hold_mid && i == n / 2) begin
        drain();
      end
      r = $urandom_range(99);
      c.handle_in = 31'($urandom());
      c.id_in = $urandom();
      if (r < 40 || used_slots.size() == 0) begin
        c.func = FUNC_PUT;
      end else if (r < 60) begin
        c.func = FUNC_GET;
        if (r < 50 && live_ids.size() != 0) begin
          c.id_in = live_ids[$urandom_range(live_ids.size() - 1)];
        end else begin
          c.id_in = used_slot_id();
        end
      end else if (r < 85 && live_ids.size() != 0) begin
        c.func = FUNC_RELEASE;
        k = $urandom_range(live_ids.size() - 1);
        c.id_in = live_ids[k];
        live_ids.delete(k);
      end else if (r < 96) begin
        c.func = FUNC_RELEASE;
        c.id_in = used_slot_id();
      end else begin
        c.func = FUNC_NONE;
      end
      send(c, idle_pct);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // first id 1024 lands in slot 0
    set_start_id(32'd1023);
    send(make_cmd(FUNC_PUT, 31'h7fffffff, 32'hffffffff), 0);
    send(make_cmd(FUNC_PUT, 31'h0, 32'h0), 0);
    send(make_cmd(FUNC_PUT, 31'($urandom()), $urandom()), 0);
    send(make_cmd(FUNC_GET, 31'h0, 32'd1024), 0);
    send(make_cmd(FUNC_GET, 31'h7fffffff, 32'hfffffc01), 0);
    send(make_cmd(FUNC_GET, 31'h0, 32'h0), 0);
    send(make_cmd(FUNC_NONE, 31'h7fffffff, 32'hffffffff), 0);
    send(make_cmd(FUNC_NONE, 31'h0, 32'h0), 0);
    send(make_cmd(FUNC_RELEASE, 31'h0, 32'hfffffc00), 0);
    send(make_cmd(FUNC_RELEASE, 31'h0, 32'd1024), 0);
    // free slot 0 still matches id zero
    send(make_cmd(FUNC_RELEASE, 31'h0, 32'h0), 0);
    send(make_cmd(FUNC_GET, 31'h0, 32'h0), 0);
    send(make_cmd(FUNC_PUT, 31'($urandom()), $urandom()), 0);
    send(make_cmd(FUNC_RELEASE, 31'h0, 32'd1025), 0);

    // counter pinned on one id: every put after the first overwrites
    set_start_id(START_ID_MAX);
    repeat (3) send(make_cmd(FUNC_PUT, 31'($urandom()), $urandom()), 0);
    send(make_cmd(FUNC_GET, 31'h0, START_ID_MAX), 0);
    send(make_cmd(FUNC_RELEASE, 31'h0, START_ID_MAX), 0);

    set_start_id(START_ID_MAX - 32'd1);
    repeat (3) send(make_cmd(FUNC_PUT, 31'($urandom()), $urandom()), 0);

    set_start_id(32'd1);
    random_phase(500, 0, 1'b0);
    set_start_id($urandom_range(1, START_ID_MAX));
    random_phase(600, 61, 1'b1);
    set_start_id(START_ID_MAX - $urandom_range(1500, 3000));
    random_phase(600, 36, 1'b0);

    drain();
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("[connection_id_slot_allocator] OK");
    end else begin
      $display("[connection_id_slot_allocator] ERROR");
    end
    $finish;
  end

endmodule
